FILE: hdl/bsi_pkg.sv
// ----------------------------------------------------------------------------
// bsi_pkg: shared types and helpers of the bicubic stencil interpolator
// Fixed-point word type, constants of the Q.24 datapath, saturating helpers
// and the request/response structs of the serial arithmetic units.
// ----------------------------------------------------------------------------
package bsi_pkg;

  localparam int ARITH_W        = 64;
  localparam int FRAC           = 24;
  localparam int RATIO_INT      = 3;
  localparam int DIGIT_W        = 4;
  localparam int ROW_SUM_W      = 48;
  localparam int TAG_W          = 24;
  localparam int ROW_W          = 2;
  localparam int STENCIL_N      = 4;
  localparam int COORD_BITS_DEF = 32;
  localparam int VALUE_BITS_DEF = 32;

  typedef logic signed [ARITH_W-1:0] word_t;

  localparam word_t WORD_MAX   = {1'b0, {(ARITH_W-1){1'b1}}};
  localparam word_t WORD_MIN   = {1'b1, {(ARITH_W-1){1'b0}}};
  localparam word_t ONE_Q      = word_t'(64'd1 << FRAC);
  localparam word_t TWO_Q      = word_t'(64'd2 << FRAC);
  localparam word_t ROUND_HALF = word_t'(64'd1 << (FRAC - 1));
  localparam word_t SIX        = word_t'(64'd6);
  localparam logic [ARITH_W-1:0] QSAT_MAG =
    ARITH_W'((64'd1 << (FRAC + RATIO_INT)) - 64'd1);

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

  typedef struct packed {
    logic  start;
    logic  int_mode;
    word_t num;
    word_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t value;
  } unit_rsp_t;

  function automatic word_t sat_add(word_t a, word_t b);
    word_t s;
    s = a + b;
    if (a[ARITH_W-1] == b[ARITH_W-1] && s[ARITH_W-1] != a[ARITH_W-1]) begin
      s = a[ARITH_W-1] ? WORD_MIN : WORD_MAX;
    end
    return s;
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    word_t d;
    d = a - b;
    if (a[ARITH_W-1] != b[ARITH_W-1] && d[ARITH_W-1] != a[ARITH_W-1]) begin
      d = a[ARITH_W-1] ? WORD_MIN : WORD_MAX;
    end
    return d;
  endfunction

  function automatic logic [ARITH_W-1:0] mag(word_t v);
    logic [ARITH_W-1:0] m;
    m = v[ARITH_W-1] ? ARITH_W'(-v) : ARITH_W'(v);
    return m;
  endfunction

  // shift right by one, round to nearest, ties up
  function automatic word_t half_round(word_t v);
    word_t s;
    s = sat_add(v, word_t'(64'd1));
    return s >>> 1;
  endfunction

endpackage

FILE: hdl/bsi_if.sv
// ----------------------------------------------------------------------------
// bsi_if: channel interfaces of the bicubic stencil interpolator
// Row input channel, result channel and limiter configuration channel.
// ----------------------------------------------------------------------------
interface bsi_in_if #(
  parameter int COORD_BITS = bsi_pkg::COORD_BITS_DEF,
  parameter int VALUE_BITS = bsi_pkg::VALUE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [bsi_pkg::ROW_W-1:0]     row_index;
  logic [bsi_pkg::TAG_W-1:0]     target_index;
  logic signed [COORD_BITS-1:0]  point_x;
  logic signed [COORD_BITS-1:0]  point_y;
  logic signed [COORD_BITS-1:0]  left_inner_x;
  logic signed [COORD_BITS-1:0]  right_inner_x;
  logic signed [COORD_BITS-1:0]  row_y;
  logic signed [VALUE_BITS-1:0]  value_0;
  logic signed [VALUE_BITS-1:0]  value_1;
  logic signed [VALUE_BITS-1:0]  value_2;
  logic signed [VALUE_BITS-1:0]  value_3;

  modport source (
    output valid, row_index, target_index, point_x, point_y, left_inner_x,
           right_inner_x, row_y, value_0, value_1, value_2, value_3,
    input  ready
  );
  modport sink (
    input  valid, row_index, target_index, point_x, point_y, left_inner_x,
           right_inner_x, row_y, value_0, value_1, value_2, value_3,
    output ready
  );
endinterface

interface bsi_out_if #(
  parameter int VALUE_BITS = bsi_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] interpolated_value;
  logic [bsi_pkg::TAG_W-1:0]    result_tag;
  logic                         was_clamped;
  logic                         degenerate;

  modport source (
    output valid, interpolated_value, result_tag, was_clamped, degenerate,
    input  ready
  );
  modport sink (
    input  valid, interpolated_value, result_tag, was_clamped, degenerate,
    output ready
  );
endinterface

interface bsi_cfg_if;
  logic valid;
  logic ready;
  logic enable_limiter;

  modport source (output valid, enable_limiter, input ready);
  modport sink (input valid, enable_limiter, output ready);
endinterface

FILE: hdl/bsi_mul.sv
// ----------------------------------------------------------------------------
// bsi_mul: digit-serial Q.24 multiplier
// Sign-magnitude shift-add multiply, one 4-bit digit per cycle, saturation
// to 64 bits and a rounding shift right by the fraction width.
// ----------------------------------------------------------------------------
module bsi_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  bsi_pkg::mul_req_t req,
  output bsi_pkg::unit_rsp_t rsp
);

  localparam int W     = bsi_pkg::ARITH_W;
  localparam int DW    = bsi_pkg::DIGIT_W;
  localparam int STEPS = W / DW;
  localparam int CNT_W = $clog2(STEPS);
  localparam int PP_W  = W + DW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]         st_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [W-1:0]       ma_r;
  logic [W-1:0]       mb_r;
  logic               neg_r;
  logic [2*W-1:0]     prod_r;
  logic [2*W-1:0]     prod_nxt;
  logic [PP_W-1:0]    acc_sum;
  bsi_pkg::word_t     res_r;
  bsi_pkg::word_t     res_nxt;
  bsi_pkg::word_t     sp;
  logic               done_r;

  always_comb begin
    acc_sum  = PP_W'(prod_r[2*W-1:W]) + PP_W'(ma_r) * PP_W'(mb_r[DW-1:0]);
    prod_nxt = {acc_sum, prod_r[W-1:DW]};
    if (|prod_r[2*W-1:W-1]) begin
      sp = neg_r ? bsi_pkg::WORD_MIN : bsi_pkg::WORD_MAX;
    end else begin
      sp = neg_r ? -$signed(prod_r[W-1:0]) : $signed(prod_r[W-1:0]);
    end
    res_nxt = bsi_pkg::sat_add(sp, bsi_pkg::ROUND_HALF) >>> bsi_pkg::FRAC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= (st_r == ST_FIN);
      unique case (st_r)
        ST_IDLE: begin
          if (req.start) begin
            ma_r   <= bsi_pkg::mag(req.a);
            mb_r   <= bsi_pkg::mag(req.b);
            neg_r  <= req.a[W-1] ^ req.b[W-1];
            prod_r <= '0;
            cnt_r  <= '0;
            st_r   <= ST_RUN;
          end
        end
        ST_RUN: begin
          prod_r <= prod_nxt;
          mb_r   <= mb_r >> DW;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(STEPS - 1)) begin
            st_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          res_r  <= res_nxt;
          st_r   <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule

FILE: hdl/bsi_div.sv
// ----------------------------------------------------------------------------
// bsi_div: radix-2 serial divider
// Ratio mode gives a Q.24 quotient saturated below 8 in 27 steps; integer
// mode gives a plain truncated quotient in 64 steps. Signs by magnitude.
// ----------------------------------------------------------------------------
module bsi_div (
  input  logic               clk,
  input  logic               rst_n,
  input  bsi_pkg::div_req_t  req,
  output bsi_pkg::unit_rsp_t rsp
);

  localparam int W     = bsi_pkg::ARITH_W;
  localparam int RI    = bsi_pkg::RATIO_INT;
  localparam int QBITS = bsi_pkg::FRAC + RI;
  localparam int CNT_W = $clog2(W + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]       st_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     n_r;
  logic [W-1:0]     d_r;
  logic             neg_r;
  logic             int_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     sh_r;
  logic [W-1:0]     q_r;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             ge;
  bsi_pkg::word_t   res_r;
  logic             done_r;

  always_comb begin
    trial = {rem_r, sh_r[W-1]};
    diff  = trial - {1'b0, d_r};
    ge    = trial >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= (st_r == ST_FIN);
      unique case (st_r)
        ST_IDLE: begin
          if (req.start) begin
            n_r   <= bsi_pkg::mag(req.num);
            d_r   <= bsi_pkg::mag(req.den);
            neg_r <= req.num[W-1] ^ req.den[W-1];
            int_r <= req.int_mode;
            st_r  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (!int_r && (n_r >> RI) >= d_r) begin
            q_r  <= bsi_pkg::QSAT_MAG;
            st_r <= ST_FIN;
          end else if (int_r) begin
            q_r   <= '0;
            rem_r <= '0;
            sh_r  <= n_r;
            cnt_r <= CNT_W'(W);
            st_r  <= ST_RUN;
          end else begin
            q_r   <= '0;
            rem_r <= n_r >> RI;
            sh_r  <= {n_r[RI-1:0], {(W-RI){1'b0}}};
            cnt_r <= CNT_W'(QBITS);
            st_r  <= ST_RUN;
          end
        end
        ST_RUN: begin
          rem_r <= ge ? diff[W-1:0] : trial[W-1:0];
          sh_r  <= sh_r << 1;
          q_r   <= {q_r[W-2:0], ge};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            st_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          res_r  <= neg_r ? -$signed(q_r) : $signed(q_r);
          st_r   <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule

FILE: hdl/bicubic_stencil_interpolator_core.sv
// ----------------------------------------------------------------------------
// bicubic_stencil_interpolator_core: 4x4 bicubic interpolation with limiter
// Each stencil row is reduced to a row sum; row 3 then also forms the vertical
// weights and the result. Rows are taken one at a time; each product goes
//   through the digit-serial multiplier and each ratio through the radix-2 divider.
// Reset: sequencer idle, limiter off, inner min/max and flags cleared;
//   row sum and height stores hold no value until written.
// ----------------------------------------------------------------------------
module bicubic_stencil_interpolator_core #(
  parameter int COORD_BITS = bsi_pkg::COORD_BITS_DEF,
  parameter int VALUE_BITS = bsi_pkg::VALUE_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  bsi_in_if.sink     in_chan,
  bsi_out_if.source  out_chan,
  bsi_cfg_if.sink    cfg_chan
);

  localparam int N = bsi_pkg::STENCIL_N;

  typedef logic signed [COORD_BITS-1:0]         coord_t;
  typedef logic signed [VALUE_BITS-1:0]         value_t;
  typedef logic signed [bsi_pkg::ROW_SUM_W-1:0] rsum_t;

  localparam value_t VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam value_t VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam rsum_t  RS_MAX  = {1'b0, {(bsi_pkg::ROW_SUM_W-1){1'b1}}};
  localparam rsum_t  RS_MIN  = {1'b1, {(bsi_pkg::ROW_SUM_W-1){1'b0}}};
  localparam logic [bsi_pkg::ROW_W-1:0] ROW_FIRST = 2'd0;
  localparam logic [bsi_pkg::ROW_W-1:0] ROW_ONE   = 2'd1;
  localparam logic [bsi_pkg::ROW_W-1:0] ROW_TWO   = 2'd2;
  localparam logic [bsi_pkg::ROW_W-1:0] ROW_LAST  = 2'd3;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_XDEN   = 5'd1;
  localparam logic [4:0] ST_ADIV   = 5'd2;
  localparam logic [4:0] ST_A2     = 5'd3;
  localparam logic [4:0] ST_T0     = 5'd4;
  localparam logic [4:0] ST_W0     = 5'd5;
  localparam logic [4:0] ST_U1     = 5'd6;
  localparam logic [4:0] ST_U2     = 5'd7;
  localparam logic [4:0] ST_U3     = 5'd8;
  localparam logic [4:0] ST_W3     = 5'd9;
  localparam logic [4:0] ST_SUM    = 5'd10;
  localparam logic [4:0] ST_RSTORE = 5'd11;
  localparam logic [4:0] ST_ROWEND = 5'd12;
  localparam logic [4:0] ST_YM     = 5'd13;
  localparam logic [4:0] ST_YK     = 5'd14;
  localparam logic [4:0] ST_YDIV   = 5'd15;
  localparam logic [4:0] ST_YMUL   = 5'd16;
  localparam logic [4:0] ST_W3Y    = 5'd17;
  localparam logic [4:0] ST_RES    = 5'd18;
  localparam logic [4:0] ST_FIN    = 5'd19;

  logic [4:0]                 state_r;
  logic                       busy_r;
  logic [bsi_pkg::ROW_W-1:0]  row_r;
  logic [bsi_pkg::TAG_W-1:0]  tag_r;
  coord_t                     px_r;
  coord_t                     py_r;
  coord_t                     x1_r;
  coord_t                     x2_r;
  value_t                     v_r  [N];
  coord_t                     hs_r [N];
  rsum_t                      rs_r [N];
  value_t                     min_r;
  value_t                     max_r;
  value_t                     min_nxt;
  value_t                     max_nxt;
  logic                       degen_seen_r;
  logic                       degen_r;
  logic                       lim_en_r;
  bsi_pkg::word_t             a_r;
  bsi_pkg::word_t             oma2_r;
  bsi_pkg::word_t             tma_r;
  bsi_pkg::word_t             t_r;
  bsi_pkg::word_t             w_r [N];
  bsi_pkg::word_t             acc_r;
  bsi_pkg::word_t             wk_r;
  bsi_pkg::word_t             wsum_r;
  bsi_pkg::word_t             n_r;
  bsi_pkg::word_t             d_r;
  bsi_pkg::word_t             hm_r;
  logic [bsi_pkg::ROW_W-1:0]  idx_r;
  logic [bsi_pkg::ROW_W-1:0]  m_r;
  logic [bsi_pkg::ROW_W-1:0]  h_addr;
  bsi_pkg::word_t             h_rd;
  rsum_t                      rs_sat;
  value_t                     val_sat;
  value_t                     val_lim;
  logic                       clamp;

  logic                       out_valid_r;
  value_t                     out_val_r;
  logic [bsi_pkg::TAG_W-1:0]  out_tag_r;
  logic                       out_clamp_r;
  logic                       out_degen_r;

  bsi_pkg::mul_req_t          mul_req;
  bsi_pkg::div_req_t          div_req;
  bsi_pkg::unit_rsp_t         mul_rsp;
  bsi_pkg::unit_rsp_t         div_rsp;
  logic                       unit_done;
  logic                       in_acc;

  bsi_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  bsi_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign unit_done      = mul_rsp.done || div_rsp.done;

  // inner 2x2 min/max, restarted by row 0
  always_comb begin
    min_nxt = (in_chan.row_index == ROW_FIRST) ? VAL_MAX : min_r;
    max_nxt = (in_chan.row_index == ROW_FIRST) ? VAL_MIN : max_r;
    if (in_chan.row_index == ROW_ONE || in_chan.row_index == ROW_TWO) begin
      if (in_chan.value_1 < min_nxt) min_nxt = in_chan.value_1;
      if (in_chan.value_1 > max_nxt) max_nxt = in_chan.value_1;
      if (in_chan.value_2 < min_nxt) min_nxt = in_chan.value_2;
      if (in_chan.value_2 > max_nxt) max_nxt = in_chan.value_2;
    end
  end

  always_comb begin
    h_addr = (state_r == ST_YM) ? m_r : idx_r;
    h_rd   = bsi_pkg::word_t'(hs_r[h_addr]);

    if (acc_r > bsi_pkg::word_t'(RS_MAX)) begin
      rs_sat = RS_MAX;
    end else if (acc_r < bsi_pkg::word_t'(RS_MIN)) begin
      rs_sat = RS_MIN;
    end else begin
      rs_sat = acc_r[bsi_pkg::ROW_SUM_W-1:0];
    end

    if (acc_r > bsi_pkg::word_t'(VAL_MAX)) begin
      val_sat = VAL_MAX;
    end else if (acc_r < bsi_pkg::word_t'(VAL_MIN)) begin
      val_sat = VAL_MIN;
    end else begin
      val_sat = acc_r[VALUE_BITS-1:0];
    end

    val_lim = val_sat;
    clamp   = 1'b0;
    if (lim_en_r && min_r <= max_r) begin
      if (val_sat < min_r) begin
        val_lim = min_r;
        clamp   = 1'b1;
      end else if (val_sat > max_r) begin
        val_lim = max_r;
        clamp   = 1'b1;
      end
    end
  end

  always_comb begin
    mul_req = '0;
    div_req = '0;
    unique case (state_r)
      ST_ADIV, ST_YDIV: begin
        div_req.start = !busy_r;
        div_req.num   = n_r;
        div_req.den   = d_r;
      end
      ST_W0: begin
        div_req.start    = !busy_r;
        div_req.int_mode = 1'b1;
        div_req.num      = t_r;
        div_req.den      = bsi_pkg::SIX;
      end
      ST_A2: begin
        mul_req.start = !busy_r;
        mul_req.a     = a_r;
        mul_req.b     = a_r;
      end
      ST_T0: begin
        mul_req.start = !busy_r;
        mul_req.a     = a_r;
        mul_req.b     = oma2_r;
      end
      ST_U1: begin
        mul_req.start = !busy_r;
        mul_req.a     = a_r;
        mul_req.b     = bsi_pkg::ONE_Q + a_r;
      end
      ST_U2: begin
        mul_req.start = !busy_r;
        mul_req.a     = t_r;
        mul_req.b     = tma_r;
      end
      ST_U3: begin
        mul_req.start = !busy_r;
        mul_req.a     = oma2_r;
        mul_req.b     = tma_r;
      end
      ST_SUM: begin
        mul_req.start = !busy_r;
        mul_req.a     = w_r[idx_r];
        mul_req.b     = bsi_pkg::word_t'(v_r[idx_r]);
      end
      ST_YMUL: begin
        mul_req.start = !busy_r;
        mul_req.a     = wk_r;
        mul_req.b     = t_r;
      end
      ST_RES: begin
        mul_req.start = !busy_r;
        mul_req.a     = w_r[idx_r];
        mul_req.b     = bsi_pkg::word_t'(rs_r[idx_r]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      busy_r       <= 1'b0;
      min_r        <= VAL_MAX;
      max_r        <= VAL_MIN;
      degen_seen_r <= 1'b0;
      lim_en_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        lim_en_r <= cfg_chan.enable_limiter;
      end
      if (out_valid_r && out_chan.ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      if (mul_req.start || div_req.start) begin
        busy_r <= 1'b1;
      end
      if (unit_done) begin
        busy_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            row_r   <= in_chan.row_index;
            tag_r   <= in_chan.target_index;
            px_r    <= in_chan.point_x;
            py_r    <= in_chan.point_y;
            x1_r    <= in_chan.left_inner_x;
            x2_r    <= in_chan.right_inner_x;
            v_r[0]  <= in_chan.value_0;
            v_r[1]  <= in_chan.value_1;
            v_r[2]  <= in_chan.value_2;
            v_r[3]  <= in_chan.value_3;
            hs_r[in_chan.row_index] <= in_chan.row_y;
            min_r   <= min_nxt;
            max_r   <= max_nxt;
            if (in_chan.row_index == ROW_FIRST) begin
              degen_seen_r <= 1'b0;
            end
            state_r <= ST_XDEN;
          end
        end
        ST_XDEN: begin
          if (x2_r == x1_r) begin
            rs_r[row_r]  <= '0;
            degen_seen_r <= 1'b1;
            state_r      <= ST_ROWEND;
          end else begin
            n_r     <= bsi_pkg::sat_sub(bsi_pkg::word_t'(x2_r), bsi_pkg::word_t'(px_r));
            d_r     <= bsi_pkg::sat_sub(bsi_pkg::word_t'(x2_r), bsi_pkg::word_t'(x1_r));
            state_r <= ST_ADIV;
          end
        end
        ST_ADIV: begin
          if (unit_done) begin
            a_r     <= div_rsp.value;
            tma_r   <= bsi_pkg::TWO_Q - div_rsp.value;
            state_r <= ST_A2;
          end
        end
        ST_A2: begin
          if (unit_done) begin
            oma2_r  <= bsi_pkg::ONE_Q - mul_rsp.value;
            state_r <= ST_T0;
          end
        end
        ST_T0: begin
          if (unit_done) begin
            t_r     <= mul_rsp.value;
            state_r <= ST_W0;
          end
        end
        ST_W0: begin
          if (unit_done) begin
            w_r[0]  <= -div_rsp.value;
            state_r <= ST_U1;
          end
        end
        ST_U1: begin
          if (unit_done) begin
            t_r     <= mul_rsp.value;
            state_r <= ST_U2;
          end
        end
        ST_U2: begin
          if (unit_done) begin
            w_r[1]  <= bsi_pkg::half_round(mul_rsp.value);
            state_r <= ST_U3;
          end
        end
        ST_U3: begin
          if (unit_done) begin
            w_r[2]  <= bsi_pkg::half_round(mul_rsp.value);
            state_r <= ST_W3;
          end
        end
        ST_W3: begin
          w_r[3]  <= bsi_pkg::ONE_Q - w_r[0] - w_r[1] - w_r[2];
          acc_r   <= '0;
          idx_r   <= '0;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          if (unit_done) begin
            acc_r <= bsi_pkg::sat_add(acc_r, mul_rsp.value);
            if (idx_r == ROW_LAST) begin
              state_r <= ST_RSTORE;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        ST_RSTORE: begin
          rs_r[row_r] <= rs_sat;
          state_r     <= ST_ROWEND;
        end
        ST_ROWEND: begin
          if (row_r != ROW_LAST) begin
            state_r <= ST_IDLE;
          end else begin
            degen_r <= degen_seen_r;
            idx_r   <= ROW_FIRST;
            m_r     <= ROW_ONE;
            wk_r    <= bsi_pkg::ONE_Q;
            wsum_r  <= '0;
            state_r <= degen_seen_r ? ST_FIN : ST_YM;
          end
        end
        ST_YM: begin
          hm_r    <= h_rd;
          state_r <= ST_YK;
        end
        ST_YK: begin
          // each pair of rows meets here as k, m at least once, unless equal heights end it
          if (h_rd == hm_r) begin
            degen_r <= 1'b1;
            state_r <= ST_FIN;
          end else begin
            n_r     <= bsi_pkg::sat_sub(bsi_pkg::word_t'(py_r), hm_r);
            d_r     <= bsi_pkg::sat_sub(h_rd, hm_r);
            state_r <= ST_YDIV;
          end
        end
        ST_YDIV: begin
          if (unit_done) begin
            t_r     <= div_rsp.value;
            state_r <= ST_YMUL;
          end
        end
        ST_YMUL: begin
          if (unit_done) begin
            if (m_r == ROW_LAST) begin
              w_r[idx_r] <= mul_rsp.value;
              wsum_r     <= bsi_pkg::sat_add(wsum_r, mul_rsp.value);
              if (idx_r == ROW_TWO) begin
                state_r <= ST_W3Y;
              end else begin
                idx_r   <= idx_r + 1'b1;
                m_r     <= ROW_FIRST;
                wk_r    <= bsi_pkg::ONE_Q;
                state_r <= ST_YM;
              end
            end else begin
              m_r     <= (m_r + 1'b1 == idx_r) ? m_r + 2'd2 : m_r + 1'b1;
              wk_r    <= mul_rsp.value;
              state_r <= ST_YM;
            end
          end
        end
        ST_W3Y: begin
          w_r[3]  <= bsi_pkg::sat_sub(bsi_pkg::ONE_Q, wsum_r);
          acc_r   <= '0;
          idx_r   <= '0;
          state_r <= ST_RES;
        end
        ST_RES: begin
          if (unit_done) begin
            acc_r <= bsi_pkg::sat_add(acc_r, mul_rsp.value);
            if (idx_r == ROW_LAST) begin
              state_r <= ST_FIN;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_val_r   <= degen_r ? '0 : val_lim;
            out_clamp_r <= !degen_r && clamp;
            out_degen_r <= degen_r;
            out_tag_r   <= tag_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.interpolated_value = out_val_r;
  assign out_chan.result_tag         = out_tag_r;
  assign out_chan.was_clamped        = out_clamp_r;
  assign out_chan.degenerate         = out_degen_r;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_degen_r |-> out_val_r == '0 && !out_clamp_r)
    else $error("degenerate result carries a value");

  a_clamp_needs_en: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_clamp_r |-> lim_en_r)
    else $error("clamp flagged with limiter off");

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_req.start && div_req.start))
    else $error("both arithmetic units started together");

  a_row0_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_chan.row_index == ROW_FIRST |=> !degen_seen_r)
    else $error("row 0 transfer did not clear degenerate flag");

  a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !busy_r)
    else $error("unit busy while sequencer idle");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bicubic_stencil_interpolator_core
// Drives stencil rows through the input channel under random backpressure,
// predicts each result with a fixed-point model or takes a typed one, and
// checks every result transfer in order. Limiter toggled between phases.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic [1:0]         row;
    logic [23:0]        tag;
    logic signed [31:0] px, py, x1, x2, ry;
    logic signed [31:0] v [4];
  } stencil_row_t;

  typedef struct {
    logic signed [31:0] value;
    logic [23:0]        tag;
    logic               clamped;
    logic               degen;
  } interp_result_t;

  typedef struct {
    stencil_row_t   r;
    bit             typed;
    interp_result_t e;
  } directed_row_t;

  localparam longint ONE = 64'sd1 << 24;
  localparam int     WATCHDOG_LIMIT = 20000;
  localparam int     HOLD_CYCLES = 3000;
  localparam int     SETTLE_CYCLES = 1500;

  logic clk;
  logic rst_n;

  bsi_in_if  in_chan ();
  bsi_out_if out_chan ();
  bsi_cfg_if cfg_chan ();

  bicubic_stencil_interpolator_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .cfg_chan (cfg_chan.sink)
  );

  // predictor state
  longint         sums [4];
  longint         heights [4];
  longint         imin, imax;
  bit             degen_seen;
  bit             limiter_on;
  interp_result_t pending_results [$];
  directed_row_t  dir_rows [$];

  int     errors;
  int     send_idle_pct, recv_idle_pct;
  bit     hold_req;
  longint cyc, last_xfer;

  function automatic longint s_add(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(s);
  endfunction

  function automatic longint s_sub(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(s);
  endfunction

  function automatic longint clamp_bits(longint v, int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return s_add(v, 64'sd1 <<< (s - 1)) >>> s;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic signed [127:0] p;
    longint              q;
    p = a;
    p = p * b;
    if (p > 128'sh7FFF_FFFF_FFFF_FFFF) q = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (p < -128'sh8000_0000_0000_0000) q = 64'sh8000_0000_0000_0000;
    else q = longint'(p);
    return round_shift(q, 24);
  endfunction

  function automatic longint fx_div(longint num, longint den);
    longint unsigned n, d;
    logic [127:0]    q;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    if ((n >> 3) >= d) q = (128'd1 << 27) - 1;
    else q = ({64'd0, n} << 24) / d;
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit interpolate_row(stencil_row_t r, output interp_result_t res);
    longint px, py, x1, x2, den, a, a2, oma2, tma, acc, val, wsum, wk;
    longint w [4];
    longint v [4];
    bit     dg;
    int     k, m;
    px = r.px; py = r.py; x1 = r.x1; x2 = r.x2;
    for (k = 0; k < 4; k++) v[k] = r.v[k];
    if (r.row == 0) begin
      imin = 64'sd2147483647;
      imax = -64'sd2147483648;
      degen_seen = 0;
    end
    den = s_sub(x2, x1);
    if (den == 0) begin
      degen_seen = 1;
      sums[r.row] = 0;
    end else begin
      a = fx_div(s_sub(x2, px), den);
      a2 = fx_mul(a, a);
      oma2 = ONE - a2;
      tma = 2 * ONE - a;
      w[0] = -(fx_mul(a, oma2) / 6);
      w[1] = round_shift(fx_mul(fx_mul(a, ONE + a), tma), 1);
      w[2] = round_shift(fx_mul(oma2, tma), 1);
      w[3] = ONE - w[0] - w[1] - w[2];
      acc = 0;
      for (k = 0; k < 4; k++) acc = s_add(acc, fx_mul(w[k], v[k]));
      sums[r.row] = clamp_bits(acc, 48);
    end
    heights[r.row] = r.ry;
    if (r.row == 1 || r.row == 2) begin
      for (k = 1; k < 3; k++) begin
        if (v[k] < imin) imin = v[k];
        if (v[k] > imax) imax = v[k];
      end
    end
    if (r.row != 3) return 0;
    dg = degen_seen;
    for (k = 0; k < 4; k++)
      for (m = k + 1; m < 4; m++)
        if (s_sub(heights[k], heights[m]) == 0) dg = 1;
    res.tag = r.tag;
    res.clamped = 0;
    res.degen = dg;
    val = 0;
    if (!dg) begin
      wsum = 0;
      for (k = 0; k < 3; k++) begin
        wk = ONE;
        for (m = 0; m < 4; m++)
          if (m != k)
            wk = fx_mul(wk, fx_div(s_sub(py, heights[m]), s_sub(heights[k], heights[m])));
        w[k] = wk;
        wsum = s_add(wsum, wk);
      end
      w[3] = s_sub(ONE, wsum);
      acc = 0;
      for (k = 0; k < 4; k++) acc = s_add(acc, fx_mul(w[k], sums[k]));
      val = clamp_bits(acc, 32);
      if (limiter_on && imin <= imax) begin
        if (val < imin) begin
          val = imin;
          res.clamped = 1;
        end else if (val > imax) begin
          val = imax;
          res.clamped = 1;
        end
      end
    end
    res.value = val[31:0];
    return 1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cyc);
    errors++;
  endtask

  task automatic send_row(stencil_row_t r, bit typed, interp_result_t e);
    interp_result_t res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid = 0;
      @(negedge clk);
    end
    in_chan.valid = 1;
    in_chan.row_index = r.row;
    in_chan.target_index = r.tag;
    in_chan.point_x = r.px;
    in_chan.point_y = r.py;
    in_chan.left_inner_x = r.x1;
    in_chan.right_inner_x = r.x2;
    in_chan.row_y = r.ry;
    in_chan.value_0 = r.v[0];
    in_chan.value_1 = r.v[1];
    in_chan.value_2 = r.v[2];
    in_chan.value_3 = r.v[3];
    #1;
    while (!in_chan.ready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    last_xfer = cyc;
    if (interpolate_row(r, res)) pending_results.push_back(typed ? e : res);
  endtask

  task automatic write_limiter(bit en);
    @(negedge clk);
    cfg_chan.valid = 1;
    cfg_chan.enable_limiter = en;
    #1;
    while (!cfg_chan.ready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    limiter_on = en;
    @(negedge clk);
    cfg_chan.valid = 0;
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_chan.valid = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic stencil_row_t random_row();
    stencil_row_t r;
    r.row = 2'($urandom);
    r.tag = 24'($urandom);
    r.px = $urandom; r.py = $urandom; r.x1 = $urandom; r.x2 = $urandom;
    r.ry = $urandom;
    for (int k = 0; k < 4; k++) r.v[k] = $urandom;
    return r;
  endfunction

  task automatic send_random_target();
    stencil_row_t   r;
    interp_result_t none;
    int             h, dy, y0;
    bit             wide;
    none = '{default: 0};
    r.tag = 24'($urandom);
    r.px = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    r.py = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    dy = $urandom_range(1, 32'h0040_0000);
    if ($urandom_range(1)) dy = -dy;
    y0 = r.py - dy - int'($urandom_range(0, dy < 0 ? -dy : dy));
    wide = $urandom_range(3) == 0;
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(19) == 0) continue;
      r.row = 2'(k);
      h = $urandom_range(1, 32'h0040_0000);
      r.x1 = r.px - int'($urandom_range(0, h));
      r.x2 = ($urandom_range(29) == 0) ? r.x1 : r.x1 + h;
      r.ry = ($urandom_range(29) == 0) ? y0 : y0 + k * dy;
      for (int j = 0; j < 4; j++)
        r.v[j] = wide ? $urandom : $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      send_row(r, 0, none);
    end
  endtask

  task automatic random_phase(int n_targets);
    interp_result_t none;
    none = '{default: 0};
    for (int i = 0; i < n_targets; i++) begin
      if ($urandom_range(9) == 0) send_row(random_row(), 0, none);
      send_random_target();
    end
  endtask

  function automatic stencil_row_t mk_row(int row, int tag, int px, int py, int x1,
                                          int x2, int ry, int v0, int v1, int v2, int v3);
    stencil_row_t r;
    r.row = 2'(row); r.tag = 24'(tag);
    r.px = px; r.py = py; r.x1 = x1; r.x2 = x2; r.ry = ry;
    r.v[0] = v0; r.v[1] = v1; r.v[2] = v2; r.v[3] = v3;
    return r;
  endfunction

  function automatic void add_dir(stencil_row_t r, bit typed, interp_result_t e);
    directed_row_t d;
    d.r = r; d.typed = typed; d.e = e;
    dir_rows.push_back(d);
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  initial begin
    cyc = 0;
    last_xfer = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (cyc - last_xfer >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side
  initial begin
    interp_result_t got, want;
    int             hold;
    out_chan.ready = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_chan.ready = 0;
        for (hold = 0; hold < HOLD_CYCLES; hold++) @(negedge clk);
      end
      out_chan.ready = ($urandom_range(99) >= recv_idle_pct);
      #1;
      if (out_chan.valid && out_chan.ready) begin
        got.value = out_chan.interpolated_value;
        got.tag = out_chan.result_tag;
        got.clamped = out_chan.was_clamped;
        got.degen = out_chan.degenerate;
        @(posedge clk);
        last_xfer = cyc;
        if (pending_results.size() == 0) begin
          $display("Unexpected result transfer, tag %0h at cycle %0d", got.tag, cyc);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.value) report_mismatch("interpolated_value", got.value, want.value);
          if (got.tag !== want.tag) report_mismatch("result_tag", got.tag, want.tag);
          if (got.clamped !== want.clamped) report_mismatch("was_clamped", got.clamped, want.clamped);
          if (got.degen !== want.degen) report_mismatch("degenerate", got.degen, want.degen);
        end
      end
    end
  end

  initial begin
    interp_result_t none, degen_res;
    none = '{default: 0};
    errors = 0;
    hold_req = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 0;
    in_chan.valid = 0;
    in_chan.row_index = 0;
    in_chan.target_index = 0;
    in_chan.point_x = 0;
    in_chan.point_y = 0;
    in_chan.left_inner_x = 0;
    in_chan.right_inner_x = 0;
    in_chan.row_y = 0;
    in_chan.value_0 = 0;
    in_chan.value_1 = 0;
    in_chan.value_2 = 0;
    in_chan.value_3 = 0;
    cfg_chan.valid = 0;
    cfg_chan.enable_limiter = 0;
    for (int k = 0; k < 4; k++) begin
      sums[k] = 0;
      heights[k] = 0;
    end
    imin = 64'sd2147483647;
    imax = -64'sd2147483648;
    degen_seen = 0;
    limiter_on = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // nominal stencil, unit spacing
    for (int k = 0; k < 4; k++)
      add_dir(mk_row(k, 1, 32'h0008_0000, 32'h0018_0000, 0, 32'h0010_0000, k << 20,
                     k << 16, (k + 1) << 16, (k + 2) << 16, (k + 3) << 16), 0, none);
    // extreme coordinates and samples
    add_dir(mk_row(0, 24'hFFFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000), 0, none);
    add_dir(mk_row(1, 24'hFFFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF), 0, none);
    add_dir(mk_row(2, 24'hFFFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0,
                   32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0), 0, none);
    add_dir(mk_row(3, 24'hFFFFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000), 0, none);
    // two equal row heights
    degen_res = '{value: 0, tag: 24'h000002, clamped: 0, degen: 1};
    for (int k = 0; k < 4; k++)
      add_dir(mk_row(k, 2, 32'h0008_0000, 32'h0018_0000, 0, 32'h0010_0000,
                     (k == 2 ? 1 : k) << 20, 32'h0005_0000, 32'h0006_0000,
                     32'h0007_0000, 32'h0008_0000), k == 3, degen_res);
    // zero x spacing on the first row
    degen_res.tag = 24'h000003;
    for (int k = 0; k < 4; k++)
      add_dir(mk_row(k, 3, 32'h0008_0000, 32'h0018_0000, k == 0 ? 32'h0010_0000 : 0,
                     32'h0010_0000, k << 20, 1, 2, 3, 4), k == 3, degen_res);
    // last row alone, reusing stored rows
    add_dir(mk_row(3, 4, 32'h0004_0000, 32'h0014_0000, 0, 32'h0010_0000, 32'h0030_0000,
                   32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000), 0, none);

    write_limiter(0);
    foreach (dir_rows[i]) send_row(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].e);
    drain_and_settle();

    write_limiter(1);
    send_idle_pct = 20;
    recv_idle_pct = 49;
    random_phase(160);
    drain_and_settle();

    write_limiter(0);
    send_idle_pct = 49;
    recv_idle_pct = 20;
    random_phase(160);
    drain_and_settle();

    write_limiter(1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1;
    random_phase(160);
    drain_and_settle();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
